FILE: rtl/core/dmht_pkg.sv
// Shared constants, codes and types of the direct-mapped hash table.
package dmht_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = 13;
    localparam int KEY_W         = 64;
    localparam int MOVE_W        = 32;
    localparam int STEP_W        = $clog2(KEY_W + 1);
    localparam int SLOT_MAX      = (TABLE_ENTRIES < 8191) ? TABLE_ENTRIES : 8191;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 13'd4096;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_PROBE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] REG_EMPTY_MOVE  = 2'd1;

    // Last member sits in the lowest bits: key first on the bus.
    typedef struct packed {
        logic [1:0]        bound;
        logic signed [15:0] score;
        logic [7:0]        depth;
        logic [MOVE_W-1:0] move;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic              pad;
        logic [CNT_W-1:0]  occupied;
        logic [1:0]        bound;
        logic signed [15:0] score;
        logic [7:0]        depth;
        logic [MOVE_W-1:0] move;
    } result_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } mod_res_t;

    localparam int ENTRY_W  = $bits(entry_t);
    localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_DATA_W = $bits(result_t);

endpackage

FILE: rtl/core/dmht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/dmht_mod.sv
// Bit-serial restoring remainder unit: 64-bit key modulo the slot count.
module dmht_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dmht_pkg::KEY_W-1:0]     dividend,
    input  logic [dmht_pkg::CNT_W-1:0]     divisor,
    output dmht_pkg::mod_res_t             res
);
    import dmht_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    // Shift one dividend bit in, subtract when the divisor fits.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[KEY_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(KEY_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign res.done = done_reg;
    assign res.rem  = IDX_W'(rem_reg);

endmodule

FILE: rtl/core/direct_mapped_hash_table.sv
// Top level of the direct-mapped, always-replace hash table.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tdata: key, move_in, depth_in, score_in,
//                                         bound_in; s_tuser: action
//  m_*      out        m_tvalid/m_tready  m_tdata: move_out, depth_out, score_out,
//                                         bound_out, occupied; m_tuser: hit
//  cfg_*    in         cfg_we             cfg_index, cfg_data
//
// Store and probe pass in order through the bit-serial remainder unit, a register
// that latches the slot, the RAM read and a compare-and-write-back step; the next
// transaction is taken once the sequencer is back in idle.
// A clear walks every slot through the single RAM write port before its result.
// An unused action code goes straight to the result step.
// After reset, and after any write to entry_count, the same sweep of every slot
// runs with s_tready low; configuration writes are still taken.
// A finished result sits in an output register, so the next transaction is
// accepted while m_tready stalls; only the following result waits for it.
module direct_mapped_hash_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key[63:0], move_in[95:64], depth_in[103:96], score_in[119:104],
    // bound_in[121:120], zero fill above
    input  logic [dmht_pkg::S_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // move_out[31:0], depth_out[39:32], score_out[55:40], bound_out[57:56],
    // occupied[70:58], zero fill at bit 71
    output logic [dmht_pkg::M_DATA_W-1:0] m_tdata,
    // hit[0]
    output logic [0:0]                    m_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import dmht_pkg::*;

    localparam logic [2:0] ST_SWEEP  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [MOVE_W-1:0] empty_move_reg;
    logic [MOVE_W-1:0] wipe_code_reg;
    logic [IDX_W-1:0]  sweep_cnt_reg;
    logic              clear_pend_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic              out_valid_reg;
    logic [1:0]        action_reg;
    entry_t            item_reg;
    logic [IDX_W-1:0]  idx_reg;
    result_t           out_data_reg;
    logic              out_hit_reg;

    logic              cfg_resize;
    logic              in_acc;
    logic [1:0]        in_action;
    entry_t            in_entry;
    logic [CNT_W-1:0]  slots_used;
    logic              out_free;
    logic              fin_go;
    logic              sweep_last;
    logic              mod_start;
    mod_res_t          mod_res;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              is_store;
    logic              is_probe;
    logic              was_full;
    logic              now_full;
    logic              hit;
    logic [CNT_W-1:0]  occ_upd;
    result_t           res_word;

    // A write to entry_count wipes the table, so hold off any new transaction then.
    assign cfg_resize = cfg_we && (cfg_index == REG_ENTRY_COUNT);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_resize;
    assign in_acc     = s_tvalid && s_tready;
    assign in_action  = s_tuser;
    assign in_entry   = entry_t'(s_tdata[ENTRY_W-1:0]);
    assign out_free   = !out_valid_reg || m_tready;
    assign fin_go     = (state_reg == ST_FINISH) && out_free;
    assign sweep_last = sweep_cnt_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign mod_start  = in_acc && ((in_action == ACT_STORE) || (in_action == ACT_PROBE));

    // Clamp the divisor: zero acts as one, anything past the table as the table size.
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            slots_used = CNT_W'(1);
        end
        else if (entry_count_reg > CNT_W'(SLOT_MAX))
        begin
            slots_used = CNT_W'(SLOT_MAX);
        end
        else
        begin
            slots_used = entry_count_reg;
        end
    end

    dmht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (in_entry.key),
        .divisor  (slots_used),
        .res      (mod_res)
    );

    // The sweep owns the write port; otherwise a finishing store writes its slot.
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            ram_we          = 1'b1;
            ram_waddr       = sweep_cnt_reg;
            ram_wdata       = '0;
            ram_wdata.move  = wipe_code_reg;
        end
        else
        begin
            ram_we    = fin_go && (action_reg == ACT_STORE);
            ram_waddr = idx_reg;
            ram_wdata = item_reg;
        end
    end

    // Read address stays on the item's slot, so read data holds through a stall.
    dmht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign is_store = action_reg == ACT_STORE;
    assign is_probe = action_reg == ACT_PROBE;
    assign was_full = |rd_entry.key;
    assign now_full = |item_reg.key;
    assign hit      = is_probe && (rd_entry.key == item_reg.key);

    // Track occupancy as slots change between empty and full.
    always_comb
    begin
        occ_upd = occ_reg;
        if (is_store && was_full && !now_full)
        begin
            occ_upd = occ_reg - 1'b1;
        end
        else if (is_store && !was_full && now_full)
        begin
            occ_upd = occ_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_word          = '0;
        res_word.occupied = occ_upd;
        if (hit)
        begin
            res_word.move  = rd_entry.move;
            res_word.depth = rd_entry.depth;
            res_word.score = rd_entry.score;
            res_word.bound = rd_entry.bound;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = clear_pend_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_action inside {ACT_STORE, ACT_PROBE})
                    begin
                        state_next = ST_DIV;
                    end
                    else if (in_action == ACT_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                if (mod_res.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_resize)
        begin
            state_next = ST_SWEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            entry_count_reg <= ENTRY_COUNT_RST;
            empty_move_reg  <= '0;
            wipe_code_reg   <= '0;
            sweep_cnt_reg   <= '0;
            clear_pend_reg  <= 1'b0;
            occ_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_W-1:0];
                    REG_EMPTY_MOVE:  empty_move_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            // Start a wipe with the move code as it stands now.
            if (cfg_resize || (in_acc && (in_action == ACT_CLEAR)))
            begin
                wipe_code_reg  <= empty_move_reg;
                sweep_cnt_reg  <= '0;
                clear_pend_reg <= !cfg_resize;
                occ_reg        <= '0;
            end
            else
            begin
                if (state_reg == ST_SWEEP)
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                end
                if (fin_go)
                begin
                    occ_reg        <= occ_upd;
                    clear_pend_reg <= 1'b0;
                end
            end

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            action_reg <= in_action;
            item_reg   <= in_entry;
        end
        if ((state_reg == ST_DIV) && mod_res.done)
        begin
            idx_reg <= mod_res.rem;
        end
        if (fin_go)
        begin
            out_data_reg <= res_word;
            out_hit_reg  <= hit;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_hit_reg;

endmodule

FILE: rtl/core/dmht_chk.sv
// Port-level checker for the hash table, bound to the top level.
module dmht_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dmht_pkg::M_DATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          cfg_we,
    input logic [1:0]                    cfg_index
);
    import dmht_pkg::*;

    result_t res_view;

    assign res_view = result_t'(m_tdata);

    // One transaction at a time: the sequencer drops ready after an acceptance.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high in the cycle after an accepted transaction");

    // A resize starts the wipe sweep at once.
    a_resize_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_ENTRY_COUNT) |=> !s_tready)
        else $error("s_tready high right after an entry_count write");

    // A miss carries zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (res_view.move == '0) && (res_view.depth == '0)
            && (res_view.score == '0) && (res_view.bound == '0))
        else $error("miss result with nonzero fields");

    // Occupancy never exceeds the table size.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res_view.occupied <= CNT_W'(SLOT_MAX))
        else $error("occupied count beyond table size");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed or dropped while stalled");

endmodule

bind direct_mapped_hash_table dmht_chk u_dmht_chk (.*);
